@@ rtl/core/bpa_pkg.sv @@
// shared types, constants and helpers for the bitmap page allocator
package bpa_pkg;

  localparam int unsigned NUM_PAGES = 65536;
  localparam int unsigned MAP_WORDS = (NUM_PAGES + 31) / 32;
  localparam int unsigned WORD_AW   = $clog2(MAP_WORDS);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);
  // highest page count reachable with 16-bit page numbers
  localparam logic [16:0] PAGE_LIMIT = 17'((NUM_PAGES > 65536) ? 65536 : NUM_PAGES);

  localparam int unsigned CFG_AW = 4;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_DBL_FREE = 2'd2,
    ST_BAD_PAGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_LOWEST_PAGE = 2'd0,
    REG_SCAN_START  = 2'd1,
    REG_SCAN_END    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] page_number;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] page_granted;
    logic [16:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] lowest_page;
    logic [15:0] scan_start;
    logic [16:0] scan_end;
  } cfg_t;

  // control of the shared word unit: search window [lo, hi) and update mode
  typedef struct packed {
    logic [4:0] lo;
    logic [5:0] hi;
    logic       set_mode;
  } wu_ctl_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  idx;
    logic [31:0] wdata;
  } wu_res_t;

  function automatic logic [WORD_AW-1:0] page_word(logic [16:0] p);
    page_word = WORD_AW'(p >> 5);
  endfunction

endpackage

@@ rtl/core/bitmap_page_allocator.sv @@
// top level: sequencer around the used-map memory and the shared word unit
//
//  channel   direction  handshake              payload
//  request   in         start / busy           req_i   (kind, page_number)
//  result    out        done_o strobe          rsp_o   (status, page_granted, free_count)
//  config    in/out     apb psel/penable/...   paddr, pwdata, prdata
//
// after reset a clearing pass writes every map word to all ones, one word a cycle
// (MAP_WORDS = 2048 words); busy stays high until it is done.
// free and allocate with a hint hit: the word read at the accepting edge is checked in
// S_FREE_CHK or S_HINT_CHK, and the result is registered into done_o and rsp_o.
// a missed hint walks the window in S_SCAN_CHK, one read of the single port per word.
// busy is high while a transaction is in flight; results cannot be stalled.
module bitmap_page_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  bpa_pkg::req_t              req_i,
  output logic                       done_o,
  output bpa_pkg::rsp_t              rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpa_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_CHK,
    S_HINT_CHK,
    S_SCAN_CHK
  } state_e;

  state_e state_q, state_d;

  logic [bpa_pkg::WORD_AW-1:0] clr_q, clr_d;
  logic [15:0]                 page_q, page_d;
  logic [15:0]                 hint_q, hint_d;
  logic [16:0]                 count_q, count_d;
  logic [16:0]                 pos_q, pos_d;
  logic                        done_q, done_d;
  bpa_pkg::rsp_t               rsp_q, rsp_d;

  bpa_pkg::cfg_t               cfg;
  logic [16:0]                 lim;
  logic [16:0]                 nxt_pos;

  logic                        ram_we;
  logic [bpa_pkg::WORD_AW-1:0] ram_addr;
  logic [31:0]                 ram_wdata;
  logic [31:0]                 ram_rdata;

  bpa_pkg::wu_ctl_t            wu_ctl;
  bpa_pkg::wu_res_t            wu_res;

  bpa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bpa_map_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bpa_word_unit u_wu (
    .word_i (ram_rdata),
    .ctl_i  (wu_ctl),
    .res_o  (wu_res)
  );

  assign lim     = (cfg.scan_end < bpa_pkg::PAGE_LIMIT) ? cfg.scan_end : bpa_pkg::PAGE_LIMIT;
  assign nxt_pos = {pos_q[16:5] + 12'd1, 5'd0};

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    page_d    = page_q;
    hint_d    = hint_q;
    count_d   = count_q;
    pos_d     = pos_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_addr  = clr_q;
    ram_wdata = wu_res.wdata;
    wu_ctl.lo       = '0;
    wu_ctl.hi       = 6'd32;
    wu_ctl.set_mode = 1'b1;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '1;
        clr_d     = clr_q + bpa_pkg::WORD_AW'(1);
        if (clr_q == bpa_pkg::LAST_WORD) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          page_d = req_i.page_number;
          if (req_i.kind == bpa_pkg::KIND_FREE) begin
            ram_addr = bpa_pkg::page_word({1'b0, req_i.page_number});
            state_d  = S_FREE_CHK;
          end else begin
            ram_addr = bpa_pkg::page_word({1'b0, hint_q});
            state_d  = S_HINT_CHK;
          end
        end
      end

      S_FREE_CHK: begin
        wu_ctl.lo       = page_q[4:0];
        wu_ctl.hi       = {1'b0, page_q[4:0]} + 6'd1;
        wu_ctl.set_mode = 1'b0;
        rsp_d.page_granted = '0;
        if (page_q < cfg.lowest_page || !({1'b0, page_q} < bpa_pkg::PAGE_LIMIT)) begin
          rsp_d.status = bpa_pkg::ST_BAD_PAGE;
        end else if (wu_res.found) begin
          rsp_d.status = bpa_pkg::ST_DBL_FREE;
        end else begin
          ram_we       = 1'b1;
          ram_addr     = bpa_pkg::page_word({1'b0, page_q});
          hint_d       = page_q;
          count_d      = count_q + 17'd1;
          rsp_d.status = bpa_pkg::ST_OK;
        end
        rsp_d.free_count = count_d;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_HINT_CHK: begin
        wu_ctl.lo = hint_q[4:0];
        wu_ctl.hi = {1'b0, hint_q[4:0]} + 6'd1;
        if (wu_res.found && ({1'b0, hint_q} < bpa_pkg::PAGE_LIMIT)) begin
          ram_we             = 1'b1;
          ram_addr           = bpa_pkg::page_word({1'b0, hint_q});
          count_d            = count_q - 17'd1;
          rsp_d.status       = bpa_pkg::ST_OK;
          rsp_d.page_granted = hint_q;
          rsp_d.free_count   = count_d;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end else if ({1'b0, cfg.scan_start} < lim) begin
          ram_addr = bpa_pkg::page_word({1'b0, cfg.scan_start});
          pos_d    = {1'b0, cfg.scan_start};
          state_d  = S_SCAN_CHK;
        end else begin
          rsp_d.status       = bpa_pkg::ST_NO_MEM;
          rsp_d.page_granted = '0;
          rsp_d.free_count   = count_q;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_SCAN_CHK: begin
        wu_ctl.lo = pos_q[4:0];
        // the last word of the window is cut at the scan limit
        wu_ctl.hi = (pos_q[16:5] == lim[16:5]) ? {1'b0, lim[4:0]} : 6'd32;
        if (wu_res.found) begin
          ram_we             = 1'b1;
          ram_addr           = bpa_pkg::page_word(pos_q);
          count_d            = count_q - 17'd1;
          rsp_d.status       = bpa_pkg::ST_OK;
          rsp_d.page_granted = 16'({pos_q[16:5], wu_res.idx});
          rsp_d.free_count   = count_d;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end else if (nxt_pos < lim) begin
          ram_addr = bpa_pkg::page_word(nxt_pos);
          pos_d    = nxt_pos;
        end else begin
          rsp_d.status       = bpa_pkg::ST_NO_MEM;
          rsp_d.page_granted = '0;
          rsp_d.free_count   = count_q;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      hint_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hint_q  <= hint_d;
      count_q <= count_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    pos_q  <= pos_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // a result never shows in the cycle right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result strobe right after accept");

  // a rejected transaction leaves the free count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != bpa_pkg::ST_OK) |-> (count_q == $past(count_q)))
    else $error("free count moved on a rejected transaction");

  // a failed transaction may not grant a page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != bpa_pkg::ST_OK) |-> (rsp_o.page_granted == 16'd0))
    else $error("page granted on a failed transaction");

  // the map is only written while a transaction or the clearing pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("map write while idle");
`endif

endmodule

@@ rtl/core/bpa_map_ram.sv @@
// single-port used-map memory with registered read data
module bpa_map_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bpa_pkg::WORD_AW-1:0] addr_i,
  input  logic [31:0]                 wdata_i,
  output logic [31:0]                 rdata_o
);

  logic [31:0] mem [bpa_pkg::MAP_WORDS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bpa_word_unit.sv @@
// shared word unit: lowest free bit inside a window and the updated word
module bpa_word_unit (
  input  logic [31:0]      word_i,
  input  bpa_pkg::wu_ctl_t ctl_i,
  output bpa_pkg::wu_res_t res_o
);

  logic [31:0] cand;
  logic        found;
  logic [4:0]  idx;
  logic [4:0]  upd_bit;

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      cand[k] = ~word_i[k] && (5'(k) >= ctl_i.lo) && (6'(k) < ctl_i.hi);
    end
  end

  // priority pick of the lowest candidate
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int k = 31; k >= 0; k--) begin
      if (cand[k]) begin
        found = 1'b1;
        idx   = 5'(k);
      end
    end
  end

  assign upd_bit = ctl_i.set_mode ? idx : ctl_i.lo;

  always_comb begin
    res_o.found = found;
    res_o.idx   = idx;
    res_o.wdata = word_i;
    if (ctl_i.set_mode) begin
      res_o.wdata[upd_bit] = 1'b1;
    end else begin
      res_o.wdata[upd_bit] = 1'b0;
    end
  end

endmodule

@@ rtl/core/bpa_cfg_regs.sv @@
// apb configuration registers of the page allocator
module bpa_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpa_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bpa_pkg::cfg_t              cfg_o
);

  bpa_pkg::cfg_t cfg_q;
  bpa_pkg::cfg_t cfg_d;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        bpa_pkg::REG_LOWEST_PAGE: cfg_d.lowest_page = pwdata[15:0];
        bpa_pkg::REG_SCAN_START:  cfg_d.scan_start  = pwdata[15:0];
        bpa_pkg::REG_SCAN_END:    cfg_d.scan_end    = pwdata[16:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bpa_pkg::REG_LOWEST_PAGE: prdata = {16'd0, cfg_q.lowest_page};
      bpa_pkg::REG_SCAN_START:  prdata = {16'd0, cfg_q.scan_start};
      bpa_pkg::REG_SCAN_END:    prdata = {15'd0, cfg_q.scan_end};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lowest_page <= 16'd256;
      cfg_q.scan_start  <= 16'd0;
      cfg_q.scan_end    <= 17'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ dv/tb_top.sv @@
// testbench for bitmap_page_allocator: directed table and random phases checked by a predictor
`timescale 1ns / 100ps

module tb_top;

  // worst case: clearing pass, then every item a full map scan plus a long gap, almost four times
  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 73;

  typedef struct {
    bit                 is_cfg;
    bpa_pkg::reg_idx_e  reg_sel;
    int unsigned        value;
    bpa_pkg::req_t      req;
    bit                 fixed;
    bpa_pkg::rsp_t      rsp;
  } step_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  bpa_pkg::req_t              req_i;
  logic                       done_o;
  bpa_pkg::rsp_t              rsp_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bpa_pkg::CFG_AW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  // predictor state
  logic [31:0]   used_words [bpa_pkg::MAP_WORDS];
  logic [15:0]   hint_pg;
  logic [16:0]   nfree;
  bpa_pkg::cfg_t cfg;

  bpa_pkg::rsp_t outcome_q [$];
  logic [15:0]   recent_pg [$];
  step_t         dir_plan [$];
  int            fails = 0;
  int            cycles = 0;

  bitmap_page_allocator DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("bitmap_page_allocator verification failed");
      $finish;
    end
  end

  function automatic bit page_used(int unsigned p);
    if (p >= bpa_pkg::NUM_PAGES) return 1'b1;
    return used_words[p >> 5][p & 31];
  endfunction

  function automatic void mark_page(int unsigned p, bit v);
    if (p < bpa_pkg::NUM_PAGES) used_words[p >> 5][p & 31] = v;
  endfunction

  // applies one request to the page map and returns the result it should give
  function automatic bpa_pkg::rsp_t page_op_outcome(bpa_pkg::req_t r);
    bpa_pkg::rsp_t o;
    int unsigned   pg;
    int unsigned   lim;
    int unsigned   i;
    bit            found;
    o = '0;
    o.status = bpa_pkg::ST_OK;
    pg = r.page_number;
    if (r.kind == bpa_pkg::KIND_FREE) begin
      if (pg < cfg.lowest_page || pg >= bpa_pkg::NUM_PAGES) begin
        o.status = bpa_pkg::ST_BAD_PAGE;
      end else if (!page_used(pg)) begin
        o.status = bpa_pkg::ST_DBL_FREE;
      end else begin
        mark_page(pg, 1'b0);
        hint_pg = r.page_number;
        nfree = nfree + 17'd1;
      end
    end else begin
      lim = cfg.scan_end;
      if (lim > bpa_pkg::NUM_PAGES) lim = bpa_pkg::NUM_PAGES;
      if (lim > 65536) lim = 65536;
      found = 1'b0;
      i = 0;
      if (!page_used(hint_pg)) begin
        i = hint_pg;
        found = 1'b1;
      end else begin
        i = cfg.scan_start;
        while (i < lim && !found) begin
          if ((i & 31) == 0 && used_words[i >> 5] == 32'hFFFF_FFFF) begin
            i += 32;
          end else if (!page_used(i)) begin
            found = 1'b1;
          end else begin
            i++;
          end
        end
      end
      if (found) begin
        mark_page(i, 1'b1);
        nfree = nfree - 17'd1;
        o.page_granted = i[15:0];
      end else begin
        o.status = bpa_pkg::ST_NO_MEM;
      end
    end
    o.free_count = nfree;
    return o;
  endfunction

  function automatic step_t op_row(bpa_pkg::kind_e k, logic [15:0] pg);
    step_t s;
    s.is_cfg  = 1'b0;
    s.reg_sel = bpa_pkg::REG_LOWEST_PAGE;
    s.value   = 0;
    s.req     = '{kind: k, page_number: pg};
    s.fixed   = 1'b0;
    s.rsp     = '0;
    return s;
  endfunction

  function automatic step_t op_row_fixed(bpa_pkg::kind_e k, logic [15:0] pg,
                                         bpa_pkg::status_e st,
                                         logic [15:0] g, logic [16:0] c);
    step_t s;
    s = op_row(k, pg);
    s.fixed = 1'b1;
    s.rsp   = '{status: st, page_granted: g, free_count: c};
    return s;
  endfunction

  function automatic step_t cfg_row(bpa_pkg::reg_idx_e idx, int unsigned v);
    step_t s;
    s = op_row(bpa_pkg::KIND_ALLOC, 16'h0);
    s.is_cfg  = 1'b1;
    s.reg_sel = idx;
    s.value   = v;
    return s;
  endfunction

  // lower start and wait until every pending transaction has returned
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic issue(bpa_pkg::req_t r, bit fixed, bpa_pkg::rsp_t fixed_rsp);
    bpa_pkg::rsp_t p;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    p = page_op_outcome(r);
    outcome_q.push_back(fixed ? fixed_rsp : p);
    if (p.status == bpa_pkg::ST_OK) begin
      recent_pg.push_back(r.kind == bpa_pkg::KIND_FREE ? r.page_number : p.page_granted);
      if (recent_pg.size() > 16) void'(recent_pg.pop_front());
    end
  endtask

  // register write then read-back, only while the allocator is idle
  task automatic cfg_write(bpa_pkg::reg_idx_e idx, int unsigned v);
    logic [31:0] want;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      bpa_pkg::REG_LOWEST_PAGE: cfg.lowest_page = v[15:0];
      bpa_pkg::REG_SCAN_START:  cfg.scan_start  = v[15:0];
      default:                  cfg.scan_end    = v[16:0];
    endcase
    want = (idx == bpa_pkg::REG_SCAN_END) ? (v & 32'h1FFFF) : (v & 32'hFFFF);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (outcome_q.size() == 0) begin
        $error("result with no pending transaction: status %0d page %0d", rsp_o.status,
               rsp_o.page_granted);
        fails++;
      end else begin
        bpa_pkg::rsp_t e;
        e = outcome_q.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_o.status);
          fails++;
        end
        if (rsp_o.page_granted !== e.page_granted) begin
          $error("page_granted: expected %0d, got %0d", e.page_granted, rsp_o.page_granted);
          fails++;
        end
        if (rsp_o.free_count !== e.free_count) begin
          $error("free_count: expected %0d, got %0d", e.free_count, rsp_o.free_count);
          fails++;
        end
      end
    end
  end

  initial begin
    int            ph;
    int            n;
    int            r;
    int            base;
    int            lo;
    int            ss;
    int            se;
    int            gap;
    bit            quiet;
    bpa_pkg::req_t rq;
    step_t         row;

    rst_ni  <= 1'b0;
    start   <= 1'b0;
    req_i   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    foreach (used_words[w]) used_words[w] = 32'hFFFF_FFFF;
    hint_pg = 16'd0;
    nfree   = 17'd0;
    cfg.lowest_page = 16'd256;
    cfg.scan_start  = 16'd0;
    cfg.scan_end    = 17'd0;

    // reset values: lowest 256, empty scan window
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_ALLOC, 16'h0000, bpa_pkg::ST_NO_MEM,
                                    16'd0, 17'd0));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_FREE, 16'd0, bpa_pkg::ST_BAD_PAGE,
                                    16'd0, 17'd0));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_FREE, 16'd255, bpa_pkg::ST_BAD_PAGE,
                                    16'd0, 17'd0));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_FREE, 16'hFFFF, bpa_pkg::ST_OK,
                                    16'd0, 17'd1));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_FREE, 16'hFFFF, bpa_pkg::ST_DBL_FREE,
                                    16'd0, 17'd1));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_ALLOC, 16'h1234, bpa_pkg::ST_OK,
                                    16'hFFFF, 17'd0));
    // hint is now stale and the window is empty
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_ALLOC, 16'hFFFF, bpa_pkg::ST_NO_MEM,
                                    16'd0, 17'd0));
    dir_plan.push_back(op_row(bpa_pkg::KIND_FREE, 16'd256));
    dir_plan.push_back(op_row(bpa_pkg::KIND_FREE, 16'd300));
    dir_plan.push_back(op_row(bpa_pkg::KIND_ALLOC, 16'hA5A5));
    dir_plan.push_back(op_row(bpa_pkg::KIND_ALLOC, 16'h5A5A));
    // whole map in the window
    dir_plan.push_back(cfg_row(bpa_pkg::REG_LOWEST_PAGE, 0));
    dir_plan.push_back(cfg_row(bpa_pkg::REG_SCAN_START, 0));
    dir_plan.push_back(cfg_row(bpa_pkg::REG_SCAN_END, 65536));
    dir_plan.push_back(op_row(bpa_pkg::KIND_ALLOC, 16'h0));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_FREE, 16'd0, bpa_pkg::ST_OK,
                                    16'd0, 17'd1));
    dir_plan.push_back(op_row(bpa_pkg::KIND_FREE, 16'd0));
    dir_plan.push_back(op_row(bpa_pkg::KIND_FREE, 16'hFFFF));
    dir_plan.push_back(op_row(bpa_pkg::KIND_ALLOC, 16'h0));
    // scan finds page zero, then walks every map word and finds nothing
    dir_plan.push_back(op_row(bpa_pkg::KIND_ALLOC, 16'h0));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_ALLOC, 16'h0, bpa_pkg::ST_NO_MEM,
                                    16'd0, 17'd0));
    // scan start at the scan end: hint only
    dir_plan.push_back(cfg_row(bpa_pkg::REG_LOWEST_PAGE, 65535));
    dir_plan.push_back(cfg_row(bpa_pkg::REG_SCAN_START, 65535));
    dir_plan.push_back(cfg_row(bpa_pkg::REG_SCAN_END, 65535));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_FREE, 16'hFFFE, bpa_pkg::ST_BAD_PAGE,
                                    16'd0, 17'd0));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_FREE, 16'hFFFF, bpa_pkg::ST_OK,
                                    16'd0, 17'd1));
    dir_plan.push_back(op_row_fixed(bpa_pkg::KIND_ALLOC, 16'h0, bpa_pkg::ST_OK,
                                    16'hFFFF, 17'd0));
    dir_plan.push_back(op_row(bpa_pkg::KIND_ALLOC, 16'h0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_plan[k]) begin
      row = dir_plan[k];
      if (row.is_cfg) begin
        cfg_write(row.reg_sel, row.value);
      end else begin
        issue(row.req, row.fixed, row.rsp);
        pause_sender($urandom_range(0, 2));
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      base = $urandom_range(0, 65535 - 128);
      case (ph)
        0: begin
          lo = 0; ss = 0; se = 65536;
        end
        1: begin
          base = 65535 - 127; lo = 65535; ss = 65535; se = 65536;
        end
        2: begin
          lo = base; ss = $urandom_range(32768, 65535); se = $urandom_range(0, ss);
        end
        3: begin
          lo = 0; ss = base; se = base + 1;
        end
        default: begin
          lo = base - $urandom_range(0, 64);
          ss = base - $urandom_range(0, 96);
          se = base + $urandom_range(32, 400);
          if (lo < 0) lo = 0;
          if (ss < 0) ss = 0;
          if (se > 65536) se = 65536;
        end
      endcase
      cfg_write(bpa_pkg::REG_LOWEST_PAGE, lo);
      cfg_write(bpa_pkg::REG_SCAN_START, ss);
      cfg_write(bpa_pkg::REG_SCAN_END, se);
      quiet = (ph % 3 == 1);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        rq.page_number = 16'($urandom_range(0, 65535));
        if (r < 45) begin
          rq.kind = bpa_pkg::KIND_ALLOC;
        end else begin
          rq.kind = bpa_pkg::KIND_FREE;
          if (r < 80) begin
            rq.page_number = 16'(base + $urandom_range(0, 127));
          end else if (r < 90) begin
            // refree of a page that went through the allocator lately
            if (recent_pg.size() > 0)
              rq.page_number = recent_pg[$urandom_range(0, recent_pg.size() - 1)];
          end else if (r < 95 && lo > 0) begin
            rq.page_number = 16'($urandom_range(0, lo - 1));
          end
        end
        issue(rq, 1'b0, '0);

        gap = 0;
        if (!quiet) begin
          r = $urandom_range(0, 99);
          if (r >= 90)      gap = $urandom_range(8, 60);
          else if (r >= 55) gap = $urandom_range(1, 3);
        end
        pause_sender(gap);
        if ($urandom_range(0, 29) == 0) settle();
      end
    end

    settle();
    repeat (100) @(posedge clk_i);
    if (fails == 0)
      $display("bitmap_page_allocator verification clean");
    else
      $display("bitmap_page_allocator verification failed");
    $finish;
  end

endmodule
